// File: sv/assert_macros.svh
// Assertion macros used by the position unit RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define OCP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define OCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/ocp_pkg.sv
// Shared types and constants for the conic orbit position unit.
// Depends on nothing; used by every module of the unit except ocp_phase.
package ocp_pkg;

    // Width of the CORDIC x/y datapath, signed Q2.30 with headroom
    localparam int ANG_W = 34;
    // Width of the CORDIC angle accumulator, turns scaled by 2^32
    localparam int ZACC_W = 33;

    // Reciprocal of the CORDIC limit gain in Q2.30
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // Configuration register indexes
    localparam logic [1:0] REG_SEMI_MAJOR   = 2'd0;
    localparam logic [1:0] REG_ECCENTRICITY = 2'd1;
    localparam logic [1:0] REG_PERIOD       = 2'd2;

    typedef struct packed {
        logic [31:0] semi_major_axis;
        logic [15:0] eccentricity;
        logic [31:0] orbital_period;
    } cfg_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] cos_v;
        logic signed [ANG_W-1:0] sin_v;
    } trig_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:  val = 32'h20000000;
            5'd1:  val = 32'h12E4051E;
            5'd2:  val = 32'h09FB385B;
            5'd3:  val = 32'h051111D4;
            5'd4:  val = 32'h028B0D43;
            5'd5:  val = 32'h0145D7E1;
            5'd6:  val = 32'h00A2F61E;
            5'd7:  val = 32'h00517C55;
            5'd8:  val = 32'h0028BE53;
            5'd9:  val = 32'h00145F2F;
            5'd10: val = 32'h000A2F98;
            5'd11: val = 32'h000517CC;
            5'd12: val = 32'h00028BE6;
            5'd13: val = 32'h000145F3;
            5'd14: val = 32'h0000A2FA;
            5'd15: val = 32'h0000517D;
            5'd16: val = 32'h000028BE;
            5'd17: val = 32'h0000145F;
            5'd18: val = 32'h00000A30;
            5'd19: val = 32'h00000518;
            5'd20: val = 32'h0000028C;
            5'd21: val = 32'h00000146;
            5'd22: val = 32'h000000A3;
            5'd23: val = 32'h00000051;
            5'd24: val = 32'h00000029;
            5'd25: val = 32'h00000014;
            5'd26: val = 32'h0000000A;
            5'd27: val = 32'h00000005;
            5'd28: val = 32'h00000003;
            5'd29: val = 32'h00000001;
            5'd30: val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

// File: sv/ocp_phase.sv
// Pipelined restoring divider: time modulo period, then the remainder as a
// 32-bit fraction of the period. Does not depend on ocp_pkg.
module ocp_phase (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] in_time,
    input  logic [31:0] period,
    output logic        out_valid,
    output logic [31:0] out_phase
);

    // 32 steps reduce the time, 32 more steps produce the fraction bits
    localparam int STAGES = 64;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [31:0]       rem_reg  [STAGES];
    logic [31:0]       rem_next [STAGES];
    logic [31:0]       sh_reg   [STAGES];
    logic [31:0]       sh_next  [STAGES];
    logic [31:0]       q_reg    [STAGES];
    logic [31:0]       q_next   [STAGES];

    // One quotient bit per stage
    always_comb begin
        logic        v_in;
        logic [31:0] rem_in;
        logic [31:0] sh_in;
        logic [31:0] q_in;
        logic [32:0] trial;
        logic        take;
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                v_in   = in_valid;
                rem_in = '0;
                sh_in  = in_time;
                q_in   = '0;
            end else begin
                v_in   = valid_reg[k-1];
                rem_in = rem_reg[k-1];
                sh_in  = sh_reg[k-1];
                q_in   = q_reg[k-1];
            end
            trial         = {rem_in, sh_in[31]};
            take          = (trial >= {1'b0, period});
            valid_next[k] = v_in;
            rem_next[k]   = take ? 32'(trial - {1'b0, period}) : trial[31:0];
            sh_next[k]    = {sh_in[30:0], 1'b0};
            q_next[k]     = {q_in[30:0], take};
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                sh_reg[k]  <= sh_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    // Zero period gives a zero angle
    assign out_valid = valid_reg[STAGES-1];
    assign out_phase = (period == 32'd0) ? 32'd0 : q_reg[STAGES-1];

endmodule

// File: sv/ocp_cordic.sv
// Pipelined rotation-mode CORDIC: phase in turns to cosine and sine, Q2.30.
// Depends on ocp_pkg for the gain, the arctangent table and trig_t.
module ocp_cordic #(
    parameter int STEPS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         in_phase,
    output logic                out_valid,
    output ocp_pkg::trig_t      out_trig
);

    localparam int AW = ocp_pkg::ANG_W;
    localparam int ZW = ocp_pkg::ZACC_W;

    logic [STEPS-1:0]       valid_reg;
    logic [STEPS-1:0]       valid_next;
    logic signed [AW-1:0]   x_reg  [STEPS];
    logic signed [AW-1:0]   x_next [STEPS];
    logic signed [AW-1:0]   y_reg  [STEPS];
    logic signed [AW-1:0]   y_next [STEPS];
    logic signed [ZW-1:0]   z_reg  [STEPS];
    logic signed [ZW-1:0]   z_next [STEPS];
    logic [1:0]             quad_reg  [STEPS];
    logic [1:0]             quad_next [STEPS];

    logic                   map_valid_reg;
    logic signed [AW-1:0]   cos_reg;
    logic signed [AW-1:0]   cos_next;
    logic signed [AW-1:0]   sin_reg;
    logic signed [AW-1:0]   sin_next;

    // One micro-rotation per stage
    always_comb begin
        logic                 v_in;
        logic signed [AW-1:0] xi;
        logic signed [AW-1:0] yi;
        logic signed [ZW-1:0] zi;
        logic [1:0]           qi;
        logic signed [AW-1:0] dx;
        logic signed [AW-1:0] dy;
        logic signed [ZW-1:0] da;
        for (int i = 0; i < STEPS; i++) begin
            if (i == 0) begin
                v_in = in_valid;
                xi   = ocp_pkg::CORDIC_GAIN;
                yi   = '0;
                zi   = $signed({3'b000, in_phase[29:0]});
                qi   = in_phase[31:30];
            end else begin
                v_in = valid_reg[i-1];
                xi   = x_reg[i-1];
                yi   = y_reg[i-1];
                zi   = z_reg[i-1];
                qi   = quad_reg[i-1];
            end
            dx = yi >>> i;
            dy = xi >>> i;
            da = $signed({1'b0, ocp_pkg::atan_turn(5'(i))});
            valid_next[i] = v_in;
            quad_next[i]  = qi;
            if (!zi[ZW-1]) begin
                x_next[i] = xi - dx;
                y_next[i] = yi + dy;
                z_next[i] = zi - da;
            end else begin
                x_next[i] = xi + dx;
                y_next[i] = yi - dy;
                z_next[i] = zi + da;
            end
        end
    end

    // Fold the quadrant back in
    always_comb begin
        unique case (quad_reg[STEPS-1])
            2'd0: begin
                cos_next = x_reg[STEPS-1];
                sin_next = y_reg[STEPS-1];
            end
            2'd1: begin
                cos_next = -y_reg[STEPS-1];
                sin_next = x_reg[STEPS-1];
            end
            2'd2: begin
                cos_next = -x_reg[STEPS-1];
                sin_next = -y_reg[STEPS-1];
            end
            default: begin
                cos_next = y_reg[STEPS-1];
                sin_next = -x_reg[STEPS-1];
            end
        endcase
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            map_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg     <= valid_next;
            map_valid_reg <= valid_reg[STEPS-1];
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < STEPS; i++) begin
                x_reg[i]    <= x_next[i];
                y_reg[i]    <= y_next[i];
                z_reg[i]    <= z_next[i];
                quad_reg[i] <= quad_next[i];
            end
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign out_valid      = map_valid_reg;
    assign out_trig.cos_v = cos_reg;
    assign out_trig.sin_v = sin_reg;

endmodule

// File: sv/ocp_radius.sv
// Conic radius r = a(1-e^2)/(1+e*cos): multiplies, overflow check and a
// pipelined restoring divider. Depends on ocp_pkg for trig_t.
module ocp_radius (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  ocp_pkg::trig_t    in_trig,
    input  logic [31:0]       semi_major_axis,
    input  logic [15:0]       eccentricity,
    output logic              out_valid,
    output ocp_pkg::trig_t    out_trig,
    output logic [31:0]       out_radius,
    output logic              out_sat
);

    localparam int DIV_STEPS = 32;
    localparam int EP_W      = 51;
    localparam int DEN_W     = 52;
    localparam int D_W       = 35;
    localparam logic signed [DEN_W-1:0] DEN_ONE = 52'sh1_0000_0000;

    // Stage A: e^2 and e*cos
    logic              a_valid_reg;
    logic [31:0]       a_e2_reg;
    logic signed [EP_W-1:0] a_ep_reg;
    ocp_pkg::trig_t    a_trig_reg;

    // Stage B: numerator and denominator
    logic              b_valid_reg;
    logic [63:0]       b_num_reg;
    logic signed [DEN_W-1:0] b_den_reg;
    ocp_pkg::trig_t    b_trig_reg;

    // Stage C: overflow check and divider setup
    logic              c_valid_reg;
    logic              c_bad_reg;
    logic [D_W-1:0]    c_d_reg;
    logic [D_W-1:0]    c_rem_reg;
    logic [31:0]       c_lo_reg;
    ocp_pkg::trig_t    c_trig_reg;
    logic              c_ovf;

    // Divider stages
    logic [DIV_STEPS-1:0] dv_valid_reg;
    logic [DIV_STEPS-1:0] dv_valid_next;
    logic [DIV_STEPS-1:0] dv_bad_reg;
    logic [DIV_STEPS-1:0] dv_bad_next;
    logic [D_W-1:0]    dv_d_reg    [DIV_STEPS];
    logic [D_W-1:0]    dv_d_next   [DIV_STEPS];
    logic [D_W-1:0]    dv_rem_reg  [DIV_STEPS];
    logic [D_W-1:0]    dv_rem_next [DIV_STEPS];
    logic [31:0]       dv_lo_reg   [DIV_STEPS];
    logic [31:0]       dv_lo_next  [DIV_STEPS];
    logic [31:0]       dv_q_reg    [DIV_STEPS];
    logic [31:0]       dv_q_next   [DIV_STEPS];
    ocp_pkg::trig_t    dv_trig_reg  [DIV_STEPS];
    ocp_pkg::trig_t    dv_trig_next [DIV_STEPS];

    // Quotient overflows when num reaches den * 2^32
    assign c_ovf = ({3'b000, b_num_reg} >= {b_den_reg[D_W-1:0], 32'd0});

    // Front stages: valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Front stages: payload
    always_ff @(posedge aclk) begin
        if (en) begin
            a_e2_reg   <= 32'(eccentricity) * 32'(eccentricity);
            a_ep_reg   <= $signed({1'b0, eccentricity}) * $signed(in_trig.cos_v);
            a_trig_reg <= in_trig;

            b_num_reg  <= 64'(semi_major_axis) * (64'h1_0000_0000 - 64'(a_e2_reg));
            b_den_reg  <= DEN_ONE + (a_ep_reg >>> 14);
            b_trig_reg <= a_trig_reg;

            c_bad_reg  <= (b_den_reg <= 52'sd0) || c_ovf;
            c_d_reg    <= b_den_reg[D_W-1:0];
            c_rem_reg  <= {3'b000, b_num_reg[63:32]};
            c_lo_reg   <= b_num_reg[31:0];
            c_trig_reg <= b_trig_reg;
        end
    end

    // One quotient bit per divider stage
    always_comb begin
        logic           v_in;
        logic           bad_in;
        logic [D_W-1:0] d_in;
        logic [D_W-1:0] rem_in;
        logic [31:0]    lo_in;
        logic [31:0]    q_in;
        ocp_pkg::trig_t trig_in;
        logic [D_W:0]   trial;
        logic           take;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                v_in    = c_valid_reg;
                bad_in  = c_bad_reg;
                d_in    = c_d_reg;
                rem_in  = c_rem_reg;
                lo_in   = c_lo_reg;
                q_in    = '0;
                trig_in = c_trig_reg;
            end else begin
                v_in    = dv_valid_reg[k-1];
                bad_in  = dv_bad_reg[k-1];
                d_in    = dv_d_reg[k-1];
                rem_in  = dv_rem_reg[k-1];
                lo_in   = dv_lo_reg[k-1];
                q_in    = dv_q_reg[k-1];
                trig_in = dv_trig_reg[k-1];
            end
            trial            = {rem_in, lo_in[31]};
            take             = (trial >= {1'b0, d_in});
            dv_valid_next[k] = v_in;
            dv_bad_next[k]   = bad_in;
            dv_d_next[k]     = d_in;
            dv_rem_next[k]   = take ? D_W'(trial - {1'b0, d_in}) : trial[D_W-1:0];
            dv_lo_next[k]    = {lo_in[30:0], 1'b0};
            dv_q_next[k]     = {q_in[30:0], take};
            dv_trig_next[k]  = trig_in;
        end
    end

    // Divider stages: valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg <= '0;
        end else if (en) begin
            dv_valid_reg <= dv_valid_next;
        end
    end

    // Divider stages: payload
    always_ff @(posedge aclk) begin
        if (en) begin
            dv_bad_reg <= dv_bad_next;
            for (int k = 0; k < DIV_STEPS; k++) begin
                dv_d_reg[k]    <= dv_d_next[k];
                dv_rem_reg[k]  <= dv_rem_next[k];
                dv_lo_reg[k]   <= dv_lo_next[k];
                dv_q_reg[k]    <= dv_q_next[k];
                dv_trig_reg[k] <= dv_trig_next[k];
            end
        end
    end

    // Clip the radius on overflow or a non-positive denominator
    assign out_valid  = dv_valid_reg[DIV_STEPS-1];
    assign out_trig   = dv_trig_reg[DIV_STEPS-1];
    assign out_sat    = dv_bad_reg[DIV_STEPS-1];
    assign out_radius = dv_bad_reg[DIV_STEPS-1] ? 32'hFFFF_FFFF : dv_q_reg[DIV_STEPS-1];

endmodule

// File: sv/ocp_coord.sv
// Cartesian coordinates x = r*cos, z = r*sin with rounding and clipping.
// Depends on ocp_pkg for trig_t.
module ocp_coord (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  ocp_pkg::trig_t    in_trig,
    input  logic [31:0]       in_radius,
    input  logic              in_sat,
    output logic              out_valid,
    output logic [31:0]       pos_x,
    output logic [31:0]       pos_z,
    output logic [31:0]       radius,
    output logic              saturated
);

    localparam int PW = 67;
    localparam logic signed [PW-1:0] RND     = 67'sd536870912;
    localparam logic signed [PW-1:0] SAT_MAX = 67'sd2147483647;
    localparam logic signed [PW-1:0] SAT_MIN = -67'sd2147483648;

    logic                 p_valid_reg;
    logic signed [PW-1:0] p_x_reg;
    logic signed [PW-1:0] p_z_reg;
    logic [31:0]          p_radius_reg;
    logic                 p_sat_reg;

    logic                 q_valid_reg;
    logic [31:0]          q_x_reg;
    logic [31:0]          q_z_reg;
    logic [31:0]          q_radius_reg;
    logic                 q_sat_reg;

    logic [32:0]          x_next;
    logic [32:0]          z_next;

    // Round to Q8.24 and clip; top bit flags a clip
    function automatic logic [32:0] round_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] v;
        logic [32:0]          res;
        v = (p + RND) >>> 30;
        if (v > SAT_MAX) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < SAT_MIN) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    assign x_next = round_sat(p_x_reg);
    assign z_next = round_sat(p_z_reg);

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= in_valid;
            q_valid_reg <= p_valid_reg;
        end
    end

    // Multiply, then round and clip
    always_ff @(posedge aclk) begin
        if (en) begin
            p_x_reg      <= $signed({1'b0, in_radius}) * $signed(in_trig.cos_v);
            p_z_reg      <= $signed({1'b0, in_radius}) * $signed(in_trig.sin_v);
            p_radius_reg <= in_radius;
            p_sat_reg    <= in_sat;

            q_x_reg      <= x_next[31:0];
            q_z_reg      <= z_next[31:0];
            q_radius_reg <= p_radius_reg;
            q_sat_reg    <= p_sat_reg | x_next[32] | z_next[32];
        end
    end

    assign out_valid = q_valid_reg;
    assign pos_x     = q_x_reg;
    assign pos_z     = q_z_reg;
    assign radius    = q_radius_reg;
    assign saturated = q_sat_reg;

endmodule

// File: sv/orbit_conic_position_unit.sv
// Throughput: one request per cycle while the output skid entry is empty;
// every stage is a register with its valid bit.
// The phase divider (64 stages), CORDIC (CORDIC_STEPS + 1) and radius divider (35)
// set most of the depth; a two-entry output skid lets input run while a result waits.
// Reset: synchronous, active low; clears valid bits and loads register defaults.
`include "assert_macros.svh"

module orbit_conic_position_unit #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] elapsed time, Q16.16 days
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [31:0] pos_x, [63:32] pos_z, [95:64] radius
    output logic        m_tuser    // [0] saturated
);

    logic [31:0]    sma_reg;
    logic [15:0]    ecc_reg;
    logic [31:0]    per_reg;

    logic           en;
    logic           ph_valid;
    logic [31:0]    ph_phase;
    logic           cd_valid;
    ocp_pkg::trig_t cd_trig;
    logic           rd_valid;
    ocp_pkg::trig_t rd_trig;
    logic [31:0]    rd_radius;
    logic           rd_sat;
    logic           co_valid;
    logic [31:0]    co_x;
    logic [31:0]    co_z;
    logic [31:0]    co_radius;
    logic           co_sat;

    logic           out_valid_reg;
    logic [95:0]    out_data_reg;
    logic           out_sat_reg;
    logic           skid_valid_reg;
    logic [95:0]    skid_data_reg;
    logic           skid_sat_reg;
    logic           take;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sma_reg <= 32'd16777216;
            ecc_reg <= 16'd1094;
            per_reg <= 32'd23937024;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ocp_pkg::REG_SEMI_MAJOR:   sma_reg <= cfg_wdata;
                ocp_pkg::REG_ECCENTRICITY: ecc_reg <= cfg_wdata[15:0];
                ocp_pkg::REG_PERIOD:       per_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Whole pipeline holds while the skid entry is full
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    ocp_phase u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_time   (s_tdata[31:0]),
        .period    (per_reg),
        .out_valid (ph_valid),
        .out_phase (ph_phase)
    );

    ocp_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ph_valid),
        .in_phase  (ph_phase),
        .out_valid (cd_valid),
        .out_trig  (cd_trig)
    );

    ocp_radius u_radius (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .in_valid        (cd_valid),
        .in_trig         (cd_trig),
        .semi_major_axis (sma_reg),
        .eccentricity    (ecc_reg),
        .out_valid       (rd_valid),
        .out_trig        (rd_trig),
        .out_radius      (rd_radius),
        .out_sat         (rd_sat)
    );

    ocp_coord u_coord (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rd_valid),
        .in_trig   (rd_trig),
        .in_radius (rd_radius),
        .in_sat    (rd_sat),
        .out_valid (co_valid),
        .pos_x     (co_x),
        .pos_z     (co_z),
        .radius    (co_radius),
        .saturated (co_sat)
    );

    assign take = out_valid_reg && m_tready;

    // Output register and skid: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (co_valid) begin
            if (out_valid_reg && !take) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register and skid: payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_data_reg <= skid_data_reg;
                out_sat_reg  <= skid_sat_reg;
            end
        end else if (co_valid) begin
            if (out_valid_reg && !take) begin
                skid_data_reg <= {co_radius, co_z, co_x};
                skid_sat_reg  <= co_sat;
            end else begin
                out_data_reg <= {co_radius, co_z, co_x};
                out_sat_reg  <= co_sat;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

    `OCP_ASSERT_IMPLY(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `OCP_ASSERT_NEXT(a_skid_fill_on_stall, aclk, aresetn,
        !skid_valid_reg && co_valid && out_valid_reg && !m_tready, skid_valid_reg)
    `OCP_ASSERT_IMPLY(a_sat_means_clip, aclk, aresetn, out_valid_reg && out_sat_reg,
        out_data_reg[95:64] == 32'hFFFF_FFFF ||
        out_data_reg[31:0] == 32'h7FFF_FFFF || out_data_reg[31:0] == 32'h8000_0000 ||
        out_data_reg[63:32] == 32'h7FFF_FFFF || out_data_reg[63:32] == 32'h8000_0000)

endmodule

// File: tb/tb_orbit_conic_position_unit.sv
// Self-checking testbench for orbit_conic_position_unit: drives time requests, predicts
// each position from its own fixed-point conic/CORDIC calculation and compares results.
// Depends on ocp_pkg and the unit RTL.
module tb_orbit_conic_position_unit;

    localparam int STEPS     = 24;
    localparam int LATENCY   = STEPS + 102;
    localparam int MAX_CYCLES = 400000;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
        logic [31:0]        radius;
        logic               saturated;
    } position_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = ocp_pkg::REG_SEMI_MAJOR;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;   // [31:0] pos_x, [63:32] pos_z, [95:64] radius
    logic        m_tuser;   // [0] saturated

    // Shadow copy of the configuration registers
    logic [31:0] axis_q = 32'd16777216;
    logic [15:0] ecc_q = 16'd1094;
    logic [31:0] period_q = 32'd23937024;

    position_t pending_positions[$];
    int  error_count = 0;
    int  results_seen = 0;
    int  requests_sent = 0;
    int  sat_seen = 0;
    longint cycle_count = 0;
    bit  sink_hold = 1'b0;
    int  sink_idle_pct = 29;
    int  src_idle_pct = 29;

    orbit_conic_position_unit #(.CORDIC_STEPS(STEPS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Floor shift for signed values
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] turn_step(int i);
        logic [31:0] tbl[32];
        tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
                32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
                32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        return tbl[i];
    endfunction

    // Round and clip r*trig from Q2.30 to a signed 32-bit coordinate
    function automatic logic [31:0] scale_coord(longint r, longint trig, ref logic clipped);
        longint v;
        v = floor_shift(r * trig + (64'sd1 <<< 29), 30);
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
            clipped = 1'b1;
        end
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            clipped = 1'b1;
        end
        return v[31:0];
    endfunction

    // Position on the conic for one time value under the current registers
    function automatic position_t orbit_position(logic [31:0] t);
        position_t p;
        logic [31:0] phase;
        logic [63:0] rem, num, e2, q;
        longint x, y, z, dx, dy, c, s, den;
        logic [31:0] r;
        logic clipped;
        phase = '0;
        clipped = 1'b0;
        if (period_q != 0) begin
            rem = 64'(t % period_q);
            phase = 32'((rem << 32) / 64'(period_q));
        end
        z = longint'(phase[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < STEPS && i < 32; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(turn_step(i));
            end else begin
                x += dx; y -= dy; z += longint'(turn_step(i));
            end
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        e2 = 64'(ecc_q) * 64'(ecc_q);
        num = 64'(axis_q) * ((64'd1 << 32) - e2);
        den = (64'sd1 <<< 32) + floor_shift(longint'(ecc_q) * c, 14);
        if (den <= 0) begin
            r = 32'hFFFFFFFF;
            clipped = 1'b1;
        end else begin
            q = num / 64'(den);
            if (q > 64'hFFFFFFFF) begin
                r = 32'hFFFFFFFF;
                clipped = 1'b1;
            end else begin
                r = q[31:0];
            end
        end
        p.pos_x = scale_coord(longint'(r), c, clipped);
        p.pos_z = scale_coord(longint'(r), s, clipped);
        p.radius = r;
        p.saturated = clipped;
        return p;
    endfunction

    // Cycle counter and timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver backpressure, changed at the falling edge
    always @(negedge aclk) begin
        if (!aresetn || sink_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Check each accepted result against the oldest expected position
    always @(posedge aclk) begin
        position_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_positions.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                error_count++;
            end else begin
                want = pending_positions.pop_front();
                if (m_tuser) sat_seen++;
                if (m_tdata[31:0] !== want.pos_x) begin
                    $error("pos_x expected %h actual %h", want.pos_x, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[63:32] !== want.pos_z) begin
                    $error("pos_z expected %h actual %h", want.pos_z, m_tdata[63:32]);
                    error_count++;
                end
                if (m_tdata[95:64] !== want.radius) begin
                    $error("radius expected %h actual %h", want.radius, m_tdata[95:64]);
                    error_count++;
                end
                if (m_tuser !== want.saturated) begin
                    $error("saturated expected %b actual %b", want.saturated, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Offer one time request, with optional random idle first; valid stays up on return
    task automatic send_time(logic [31:0] t);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= t;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_positions.push_back(orbit_position(t));
        requests_sent++;
        @(negedge aclk);
    endtask

    // Wait for every result, then let the pipe settle
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_positions.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    // Write one register, then deassert the write enable and wait before returning
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ocp_pkg::REG_SEMI_MAJOR:   axis_q = val;
            ocp_pkg::REG_ECCENTRICITY: ecc_q = val[15:0];
            ocp_pkg::REG_PERIOD:       period_q = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    function automatic logic [31:0] random_time();
        case ($urandom_range(3))
            0: return $urandom_range(32'h0300_0000);
            1: return {8'($urandom_range(255)), 24'h0} | 32'($urandom_range(1));
            default: return $urandom;
        endcase
    endfunction

    // Directed: field extremes, zero period, radius and coordinate clipping
    task automatic test_directed;
        send_time(32'h0);
        send_time(32'hFFFFFFFF);
        send_time(32'd23937024);
        send_time(32'd5984256);
        send_time(32'd11968512);
        send_time(32'd17952768);
        send_time(32'h5555AAAA);
        drain();
        write_reg(ocp_pkg::REG_PERIOD, 32'h0);                  // zero period, theta = 0
        send_time(32'h12345678);
        send_time(32'hFFFFFFFF);
        drain();
        write_reg(ocp_pkg::REG_PERIOD, 32'h1);
        send_time(32'hAAAA5555);
        drain();
        write_reg(ocp_pkg::REG_PERIOD, 32'hFFFFFFFF);
        write_reg(ocp_pkg::REG_SEMI_MAJOR, 32'hFFFFFFFF);       // coordinates overflow
        write_reg(ocp_pkg::REG_ECCENTRICITY, 32'h0000_FFFF);    // radius overflow near apoapsis
        send_time(32'h0);
        send_time(32'h7FFFFFFF);
        send_time(32'h80000000);
        send_time(32'hBFFFFFFF);
        drain();
        write_reg(ocp_pkg::REG_SEMI_MAJOR, 32'h0);
        write_reg(ocp_pkg::REG_ECCENTRICITY, 32'h0);
        send_time(32'h40000000);
        send_time(32'hC0000000);
        drain();
    endtask

    // Random times under several register settings
    task automatic test_random_settings;
        for (int phase_n = 0; phase_n < 8; phase_n++) begin
            write_reg(ocp_pkg::REG_SEMI_MAJOR, phase_n == 0 ? 32'h0100_0000 : $urandom);
            write_reg(ocp_pkg::REG_ECCENTRICITY,
                      phase_n == 1 ? 32'h0000_FFFF : $urandom_range(65535));
            write_reg(ocp_pkg::REG_PERIOD, phase_n == 2 ? 32'h1 : ($urandom_range(1) ?
                      $urandom_range(32'h7FFF_FFFF, 1) : $urandom));
            src_idle_pct = (phase_n == 3) ? 0 : 29;
            sink_idle_pct = (phase_n == 3) ? 0 : 29;
            for (int k = 0; k < 75; k++) send_time(random_time());
            drain();
        end
        src_idle_pct = 29;
        sink_idle_pct = 29;
    endtask

    // Hold off the receiver long enough that the pipe fills and stalls input
    task automatic test_backpressure;
        write_reg(ocp_pkg::REG_SEMI_MAJOR, $urandom);
        write_reg(ocp_pkg::REG_ECCENTRICITY, $urandom_range(40000));
        write_reg(ocp_pkg::REG_PERIOD, $urandom);
        src_idle_pct = 0;
        fork
            begin
                sink_hold = 1'b1;
                repeat (LATENCY * 2 + 60) @(negedge aclk);
                sink_hold = 1'b0;
            end
            for (int k = 0; k < 200; k++) send_time($urandom);
        join
        src_idle_pct = 29;
        drain();
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random_settings();
        test_backpressure();
        drain();
        $display("Sent %0d time requests over several register settings, %0d results",
                 requests_sent, results_seen);
        $display("including %0d clipped results, zero period and stalled output", sat_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
